[sv/rlt_pkg.sv]
package rlt_pkg;

    // Default configuration of the lock bank
    localparam int NUM_LOCKS_DEF      = 8;
    localparam int NUM_REQUESTERS_DEF = 8;
    localparam int MAX_NEST_DEF       = 255;

    // Field widths fixed by the request and response formats
    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 3;
    localparam int REQ_ID_W = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    // Number of locks a request can name through its index field
    localparam int INDEX_SPAN = 1 << INDEX_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR       = 3'd0,
        OP_ACQUIRE     = 3'd1,
        OP_ACQUIRE_REC = 3'd2,
        OP_RELEASE     = 3'd3,
        OP_RELEASE_REC = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_NOT_OWNER = 3'd2,
        ST_NOT_HELD  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  lock_index;
        logic [REQ_ID_W-1:0] requester_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count_after;
        logic [REQ_ID_W-1:0] owner_after;
    } rsp_t;

endpackage

[sv/recursive_lock_table_core.sv]
// Recursive lock table: a bank of hardware locks, each with an owner and a
// nesting count. Issue an item by raising start with a request on req; the
// item is taken at that clock edge whenever busy is low. busy never rises in
// this design, so one item may be issued in every cycle. The item is held in
// the input register, where the named lock's entry is looked up and
// updated. Its response is registered in the result stage and appears on rsp
// with done high for one cycle only. The receiver cannot stall: sample rsp in
// the cycle done is high. Responses come back in issue order, and a request
// always sees the table as left by all earlier items, since the table write
// and the next item's capture share the same edge.
// Locks at or above NUM_LOCKS answer busy with count and owner zero;
// requesters at or above NUM_REQUESTERS answer busy and change nothing.
module recursive_lock_table_core
    import rlt_pkg::*;
#(
    parameter int NUM_LOCKS      = NUM_LOCKS_DEF,
    parameter int NUM_REQUESTERS = NUM_REQUESTERS_DEF,
    parameter int MAX_NEST       = MAX_NEST_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    // Only locks reachable through the index field get storage
    localparam int TableDepth = (NUM_LOCKS < INDEX_SPAN) ? NUM_LOCKS : INDEX_SPAN;
    localparam int TableIdxW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
    localparam int CapInt     = (MAX_NEST < 255) ? MAX_NEST : 255;
    localparam logic [COUNT_W-1:0] CountCap  = COUNT_W'(CapInt);
    localparam logic [6:0]         LockLimit = 7'(NUM_LOCKS);
    localparam logic [6:0]         ReqLimit  = 7'(NUM_REQUESTERS);

    // Input stage
    req_t req_reg;
    logic valid_reg;

    // Lock table
    logic [COUNT_W-1:0]  count_reg [TableDepth];
    logic [REQ_ID_W-1:0] owner_reg [TableDepth];

    // Result stage
    rsp_t rsp_reg;
    logic done_reg;

    // Lookup and update
    logic [TableIdxW-1:0] idx;
    logic                 lock_oob;
    logic                 req_oob;
    logic [COUNT_W-1:0]   cur_count;
    logic [REQ_ID_W-1:0]  cur_owner;
    logic                 held;
    logic                 mine;
    logic [COUNT_W-1:0]   count_next;
    logic [REQ_ID_W-1:0]  owner_next;
    logic [STATUS_W-1:0]  status_next;
    logic                 table_we;
    rsp_t                 rsp_next;

    assign busy = 1'b0;

    // Capture every issued item; the pipe never stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    assign idx       = req_reg.lock_index[TableIdxW-1:0];
    assign lock_oob  = {4'b0, req_reg.lock_index} >= LockLimit;
    assign req_oob   = {4'b0, req_reg.requester_id} >= ReqLimit;
    assign cur_count = count_reg[idx];
    assign cur_owner = owner_reg[idx];
    assign held      = cur_count != '0;
    assign mine      = held && (cur_owner == req_reg.requester_id);

    // Work out the entry's next value and the status in one pass
    always_comb
    begin
        count_next  = cur_count;
        owner_next  = cur_owner;
        status_next = ST_OK;
        if (req_oob)
        begin
            status_next = ST_BUSY;
        end
        else
        begin
            case (req_reg.opcode)
                OP_CLEAR:
                begin
                    count_next = '0;
                    owner_next = '0;
                end
                OP_ACQUIRE:
                begin
                    if (!held)
                    begin
                        count_next = COUNT_W'(1);
                        owner_next = req_reg.requester_id;
                    end
                    else
                    begin
                        status_next = ST_BUSY;
                    end
                end
                OP_ACQUIRE_REC:
                begin
                    if (!held)
                    begin
                        count_next = COUNT_W'(1);
                        owner_next = req_reg.requester_id;
                    end
                    else if (!mine)
                    begin
                        status_next = ST_BUSY;
                    end
                    else if (cur_count >= CountCap)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        count_next = cur_count + COUNT_W'(1);
                    end
                end
                OP_RELEASE:
                begin
                    if (!held)
                    begin
                        status_next = ST_NOT_HELD;
                    end
                    else if (!mine)
                    begin
                        status_next = ST_NOT_OWNER;
                    end
                    else
                    begin
                        count_next = '0;
                        owner_next = '0;
                    end
                end
                OP_RELEASE_REC:
                begin
                    if (!held)
                    begin
                        status_next = ST_NOT_HELD;
                    end
                    else if (!mine)
                    begin
                        status_next = ST_NOT_OWNER;
                    end
                    else if (cur_count <= COUNT_W'(1))
                    begin
                        count_next = '0;
                        owner_next = '0;
                    end
                    else
                    begin
                        count_next = cur_count - COUNT_W'(1);
                    end
                end
                default:
                begin
                    // Unknown opcode: report the entry as it stands
                    status_next = ST_OK;
                end
            endcase
        end
    end

    assign table_we = valid_reg && !lock_oob;

    always_comb
    begin
        if (lock_oob)
        begin
            rsp_next.status      = ST_BUSY;
            rsp_next.count_after = '0;
            rsp_next.owner_after = '0;
        end
        else
        begin
            rsp_next.status      = status_next;
            rsp_next.count_after = count_next;
            rsp_next.owner_after = (count_next != '0) ? owner_next : '0;
        end
    end

    // Table write: a free lock is cleared to count and owner zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TableDepth; i++)
            begin
                count_reg[i] <= '0;
                owner_reg[i] <= '0;
            end
        end
        else if (table_we)
        begin
            count_reg[idx] <= count_next;
            owner_reg[idx] <= owner_next;
        end
    end

    // Result stage: one strobe per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Every accepted item gets a response strobe
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("item accepted without a response two cycles later");

    // A response with no accepted item behind it is a phantom
    a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("response strobe without a matching item");

    // A free lock reports no owner
    a_free_no_owner : assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.count_after == '0) |-> rsp.owner_after == '0)
        else $error("owner reported on a free lock");

    // The nesting count never passes its cap
    a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.count_after <= CountCap)
        else $error("nesting count above its cap");

endmodule
